FILE: rtl/dcr_pkg.sv
// package: widths and types for the distance constraint relax block
`default_nettype none
package dcr_pkg;
  localparam int POS_W = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int REST_W = 31;
  localparam int ERR_W = 31;
  localparam int MAG_W = 35;
  localparam int D_W = 33;
  localparam int SUM_W = 68;
  localparam int PROD_W = 66;
  localparam int QROOT_STEPS = 34;
  localparam int DIV_STEPS = 66;

  typedef struct packed {
    logic pa;
    logic pb;
    logic [REST_W-1:0] rest;
  } dcr_ctl_t;
endpackage
`default_nettype wire

FILE: rtl/dcr_sqrt_stage.sv
// one step of a restoring square root: decides one result bit per stage
`default_nettype none
module dcr_sqrt_stage #(
  parameter int BIT = 0
) (
  input  wire logic                      clk,
  input  wire logic                      vld_i,
  input  wire logic [dcr_pkg::SUM_W-1:0] rem_i,
  input  wire logic [dcr_pkg::MAG_W-1:0] root_i,
  output logic                           vld_o,
  output logic [dcr_pkg::SUM_W-1:0]      rem_o,
  output logic [dcr_pkg::MAG_W-1:0]      root_o
);
  import dcr_pkg::*;
  logic [SUM_W+1:0] trial;
  logic [SUM_W-1:0] rem_r;
  logic [MAG_W-1:0] root_r;
  logic             vld_r;

  // trial = (2*root + 2^bit) << bit
  assign trial = ({{(SUM_W+2-MAG_W){1'b0}}, root_i} << (BIT + 1))
               | ({{(SUM_W+1){1'b0}}, 1'b1} << (2 * BIT));

  always_ff @(posedge clk) begin
    vld_r <= vld_i;
    if ({2'b00, rem_i} >= trial) begin
      rem_r  <= rem_i - trial[SUM_W-1:0];
      root_r <= root_i | (MAG_W'(1) << BIT);
    end else begin
      rem_r  <= rem_i;
      root_r <= root_i;
    end
  end
  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
endmodule
`default_nettype wire

FILE: rtl/dcr_div_stage.sv
// one step of a restoring divider lane: one quotient bit per stage
`default_nettype none
module dcr_div_stage (
  input  wire logic                       clk,
  input  wire logic [dcr_pkg::PROD_W-1:0] num_i,
  input  wire logic [dcr_pkg::MAG_W:0]    rem_i,
  input  wire logic [dcr_pkg::PROD_W-1:0] q_i,
  input  wire logic [dcr_pkg::MAG_W:0]    den_i,
  output logic [dcr_pkg::PROD_W-1:0]      num_o,
  output logic [dcr_pkg::MAG_W:0]         rem_o,
  output logic [dcr_pkg::PROD_W-1:0]      q_o
);
  import dcr_pkg::*;
  logic [MAG_W+1:0] sh;
  logic [MAG_W:0]   rem_r;
  logic [PROD_W-1:0] q_r, num_r;

  assign sh = {rem_i, num_i[PROD_W-1]};

  always_ff @(posedge clk) begin
    num_r <= {num_i[PROD_W-2:0], 1'b0};
    if (sh >= {1'b0, den_i}) begin
      rem_r <= (MAG_W+1)'(sh - {1'b0, den_i});
      q_r   <= {q_i[PROD_W-2:0], 1'b1};
    end else begin
      rem_r <= sh[MAG_W:0];
      q_r   <= {q_i[PROD_W-2:0], 1'b0};
    end
  end
  assign num_o = num_r;
  assign rem_o = rem_r;
  assign q_o   = q_r;
endmodule
`default_nettype wire

FILE: rtl/distance_constraint_relax.sv
// top level: pipelined verlet distance constraint projection
//
//  channel | ports                          | handshake
//  input   | in_ax .. in_rest_len           | start high, busy low
//  result  | out_new_ax .. out_degenerate   | out_valid strobe, one cycle
//
// one word enters every cycle; busy is tied low since nothing ever stalls
// stages in order: input register, delta, squares, sum, root bits, error, products,
// quotient bits, round, apply
// reset clears only the vld_r valid chain; payload registers are not reset
// the receiver cannot stall, so results are strobed out as they finish
`default_nettype none
module distance_constraint_relax #(
  parameter int FRAC_BITS = dcr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic signed [dcr_pkg::POS_W-1:0] in_ax,
  input  wire logic signed [dcr_pkg::POS_W-1:0] in_ay,
  input  wire logic signed [dcr_pkg::POS_W-1:0] in_az,
  input  wire logic signed [dcr_pkg::POS_W-1:0] in_bx,
  input  wire logic signed [dcr_pkg::POS_W-1:0] in_by_coord,
  input  wire logic signed [dcr_pkg::POS_W-1:0] in_bz,
  input  wire logic                            in_a_pinned,
  input  wire logic                            in_b_pinned,
  input  wire logic [dcr_pkg::REST_W-1:0]      in_rest_len,
  output logic                                 out_valid,
  output logic signed [dcr_pkg::POS_W-1:0]     out_new_ax,
  output logic signed [dcr_pkg::POS_W-1:0]     out_new_ay,
  output logic signed [dcr_pkg::POS_W-1:0]     out_new_az,
  output logic signed [dcr_pkg::POS_W-1:0]     out_new_bx,
  output logic signed [dcr_pkg::POS_W-1:0]     out_new_by,
  output logic signed [dcr_pkg::POS_W-1:0]     out_new_bz,
  output logic [dcr_pkg::ERR_W-1:0]            out_length_error,
  output logic                                 out_degenerate
);
  import dcr_pkg::*;
  // positions enter the scale-free integer math; FRAC_BITS only names the format
  localparam int FB = FRAC_BITS;
  localparam int DL = QROOT_STEPS + DIV_STEPS + 8;
  localparam int PW = POS_W;

  // lanes: index 0..2 = x,y,z
  typedef logic signed [PW-1:0] pos_t;
  typedef struct packed {
    pos_t [2:0] a;
    pos_t [2:0] b;
    dcr_ctl_t   ctl;
  } carry_t;

  assign busy = (FB < 0);

  // ---- delay line for points and control, one entry per pipeline stage
  carry_t carry_r [DL-1];
  logic [DL-1:0] vld_r;
  carry_t c_in;
  assign c_in.a   = {in_az, in_ay, in_ax};
  assign c_in.b   = {in_bz, in_by_coord, in_bx};
  assign c_in.ctl = '{pa: in_a_pinned, pb: in_b_pinned, rest: in_rest_len};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DL-2:0], start & ~busy};
    end
  end
  always_ff @(posedge clk) begin
    carry_r[0] <= c_in;
    for (int i = 1; i < DL-1; i++) carry_r[i] <= carry_r[i-1];
  end

  // ---- stage 1: delta and its magnitude per lane
  logic [D_W-1:0] ud_r [3];
  logic [2:0]     dneg_r;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic signed [D_W-1:0] d;
      d = $signed(carry_r[0].a[i]) - $signed(carry_r[0].b[i]);
      dneg_r[i] <= d[D_W-1];
      ud_r[i]   <= d[D_W-1] ? D_W'(-d) : d;
    end
  end

  // ---- stage 2: squares
  logic [SUM_W-1:0] sq_r [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) sq_r[i] <= SUM_W'(ud_r[i] * ud_r[i]);
  end

  // ---- stage 3: sum of squares
  logic [SUM_W-1:0] sum_r;
  always_ff @(posedge clk) sum_r <= sq_r[0] + sq_r[1] + sq_r[2];

  // side lanes of |d| and sign riding with the root
  localparam int SR = QROOT_STEPS + 3;
  logic [D_W-1:0] udd_r [SR][3];
  logic [2:0]     ndd_r [SR];
  always_ff @(posedge clk) begin
    udd_r[0] <= ud_r;
    ndd_r[0] <= dneg_r;
    for (int s = 1; s < SR; s++) begin
      udd_r[s] <= udd_r[s-1];
      ndd_r[s] <= ndd_r[s-1];
    end
  end

  // ---- stages 4..37: square root, one bit per stage, msb first
  logic [SUM_W-1:0] rem_w  [QROOT_STEPS+1];
  logic [MAG_W-1:0] root_w [QROOT_STEPS+1];
  logic [QROOT_STEPS:0] rv_w;
  assign rem_w[0]  = sum_r;
  assign root_w[0] = '0;
  assign rv_w[0]   = 1'b0;
  for (genvar k = 0; k < QROOT_STEPS; k++) begin : g_sqrt
    dcr_sqrt_stage #(.BIT(QROOT_STEPS - 1 - k)) u_sq (
      .clk(clk), .vld_i(rv_w[k]), .rem_i(rem_w[k]), .root_i(root_w[k]),
      .vld_o(rv_w[k+1]), .rem_o(rem_w[k+1]), .root_o(root_w[k+1])
    );
  end
  logic [MAG_W-1:0] mag;
  assign mag = root_w[QROOT_STEPS];

  // ---- stage 38: error term and denominator
  localparam int T0 = 3 + QROOT_STEPS;  // carry index aligned with mag
  carry_t ce;
  assign ce = carry_r[T0];
  logic [MAG_W:0]   ue_r, den_r;
  logic             eneg_r, degen_r, move_r;
  logic [ERR_W-1:0] err_r;
  always_ff @(posedge clk) begin
    logic signed [MAG_W+1:0] e;
    logic [MAG_W:0] ue;
    e  = $signed({2'b00, mag}) - $signed({(MAG_W+2-REST_W)'(0), ce.ctl.rest});
    ue = e[MAG_W+1] ? (MAG_W+1)'(-e) : e[MAG_W:0];
    ue_r    <= ue;
    eneg_r  <= e[MAG_W+1];
    err_r   <= (ue > (MAG_W+1)'({ERR_W{1'b1}})) ? {ERR_W{1'b1}} : ERR_W'(ue);
    degen_r <= (mag == '0);
    move_r  <= (mag != '0) && !(ce.ctl.pa && ce.ctl.pb);
    den_r   <= (ce.ctl.pa || ce.ctl.pb) ? {1'b0, mag} : {mag, 1'b0};
  end

  // ---- stage 39: |d_i| * |e|
  logic [PROD_W-1:0] num_r [3];
  logic [MAG_W:0]    den2_r;
  logic [2:0]        cneg_r;
  logic              degen2_r, move2_r;
  logic [ERR_W-1:0]  err2_r;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      num_r[i]  <= PROD_W'(udd_r[SR-1][i] * ue_r);
      cneg_r[i] <= ndd_r[SR-1][i] ^ eneg_r;
    end
    den2_r <= den_r; degen2_r <= degen_r; move2_r <= move_r; err2_r <= err_r;
  end

  // ---- stages 40..105: three divider lanes, one quotient bit per stage
  typedef struct packed {
    logic [MAG_W:0] den;
    logic [2:0]     cneg;
    logic           degen;
    logic           move;
    logic [ERR_W-1:0] err;
  } side_t;
  side_t side_r [DIV_STEPS+1];
  assign side_r[0] = '{den: den2_r, cneg: cneg_r, degen: degen2_r, move: move2_r,
                       err: err2_r};
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_side
    always_ff @(posedge clk) side_r[k] <= side_r[k-1];
  end

  logic [PROD_W-1:0] q_fin [3];
  logic [MAG_W:0]    r_fin [3];
  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [PROD_W-1:0] nw [DIV_STEPS+1];
    logic [MAG_W:0]    rw [DIV_STEPS+1];
    logic [PROD_W-1:0] qw [DIV_STEPS+1];
    assign nw[0] = num_r[i];
    assign rw[0] = '0;
    assign qw[0] = '0;
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_st
      dcr_div_stage u_dv (
        .clk(clk), .num_i(nw[k]), .rem_i(rw[k]), .q_i(qw[k]),
        .den_i(side_r[k].den), .num_o(nw[k+1]), .rem_o(rw[k+1]), .q_o(qw[k+1])
      );
    end
    assign q_fin[i] = qw[DIV_STEPS];
    assign r_fin[i] = rw[DIV_STEPS];
  end

  // ---- stage 106: round half away from zero, zero it if no point moves, apply sign
  localparam int CW = PROD_W + 1;
  side_t sd;
  assign sd = side_r[DIV_STEPS];
  logic signed [CW-1:0] corr_r [3];
  logic             degen3_r;
  logic [ERR_W-1:0] err3_r;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic [PROD_W-1:0] q;
      q = q_fin[i] + PROD_W'({r_fin[i], 1'b0} >= {1'b0, sd.den});
      if (!sd.move) q = '0;
      corr_r[i] <= sd.cneg[i] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end
    degen3_r <= sd.degen;
    err3_r   <= sd.err;
  end

  // ---- stage 107: move free points and saturate
  carry_t cf;
  assign cf = carry_r[DL-2];
  localparam int XW = CW + 2;
  function automatic logic [PW-1:0] sat(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] hi, lo;
    hi = XW'({1'b0, {(PW-1){1'b1}}});
    lo = -hi - XW'(1);
    if (x > hi) return hi[PW-1:0];
    if (x < lo) return lo[PW-1:0];
    return x[PW-1:0];
  endfunction

  logic [PW-1:0] na_r [3], nb_r [3];
  logic [ERR_W-1:0] err4_r;
  logic degen4_r;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic signed [XW-1:0] av, bv;
      av = XW'(cf.a[i]);
      bv = XW'(cf.b[i]);
      if (!cf.ctl.pa) av = av - XW'(corr_r[i]);
      if (!cf.ctl.pb) bv = bv + XW'(corr_r[i]);
      na_r[i] <= sat(av);
      nb_r[i] <= sat(bv);
    end
    err4_r   <= err3_r;
    degen4_r <= degen3_r;
  end

  assign out_valid        = vld_r[DL-1];
  assign out_new_ax       = na_r[0];
  assign out_new_ay       = na_r[1];
  assign out_new_az       = na_r[2];
  assign out_new_bx       = nb_r[0];
  assign out_new_by       = nb_r[1];
  assign out_new_bz       = nb_r[2];
  assign out_length_error = err4_r;
  assign out_degenerate   = degen4_r;
endmodule
`default_nettype wire

FILE: sim/dcr_checker.sv
// checker: watches both channels, predicts each constraint projection, compares results
`timescale 1ns / 100ps
`default_nettype none
module dcr_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic signed [31:0] in_ax,
  input  wire logic signed [31:0] in_ay,
  input  wire logic signed [31:0] in_az,
  input  wire logic signed [31:0] in_bx,
  input  wire logic signed [31:0] in_by_coord,
  input  wire logic signed [31:0] in_bz,
  input  wire logic               in_a_pinned,
  input  wire logic               in_b_pinned,
  input  wire logic [30:0]        in_rest_len,
  input  wire logic               out_valid,
  input  wire logic signed [31:0] out_new_ax,
  input  wire logic signed [31:0] out_new_ay,
  input  wire logic signed [31:0] out_new_az,
  input  wire logic signed [31:0] out_new_bx,
  input  wire logic signed [31:0] out_new_by,
  input  wire logic signed [31:0] out_new_bz,
  input  wire logic [30:0]        out_length_error,
  input  wire logic               out_degenerate,
  output int                      fail_count,
  output int                      pending_count
);
  typedef struct {
    logic signed [31:0] na[3];
    logic signed [31:0] nb[3];
    logic [30:0]        err;
    logic               degen;
  } projection_t;

  projection_t projection_q[$];

  function automatic logic [31:0] clamp_pos(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic projection_t project(logic signed [31:0] a_in[3],
                                          logic signed [31:0] b_in[3],
                                          logic pa, logic pb, logic [30:0] rest);
    projection_t p;
    logic signed [63:0] a[3], b[3], d[3], e, corr;
    logic [63:0] ud[3], ue, mag, den, q, r;
    logic [127:0] sum, prod, c;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      a[i] = a_in[i];
      b[i] = b_in[i];
      d[i] = a[i] - b[i];
      ud[i] = d[i] < 0 ? -d[i] : d[i];
      sum += 128'(ud[i]) * 128'(ud[i]);
    end
    // bitwise integer square root
    mag = 0;
    for (int bit_i = 63; bit_i >= 0; bit_i--) begin
      c = 128'(mag | (64'd1 << bit_i));
      if (c * c <= sum) mag = c[63:0];
    end
    e = $signed(mag) - $signed({33'd0, rest});
    ue = e < 0 ? -e : e;
    p.err = ue > 64'h7fffffff ? 31'h7fffffff : ue[30:0];
    p.degen = (mag == 0);
    if (!p.degen && !(pa && pb)) begin
      den = (pa || pb) ? mag : 2 * mag;
      for (int i = 0; i < 3; i++) begin
        prod = 128'(ud[i]) * 128'(ue);
        q = 64'(prod / den);
        r = 64'(prod % den);
        // round half away from zero on the magnitude
        if (r >= den - r) q++;
        corr = ((d[i] < 0) != (e < 0)) ? -$signed(q) : $signed(q);
        if (!pa) a[i] -= corr;
        if (!pb) b[i] += corr;
      end
    end
    for (int i = 0; i < 3; i++) begin
      p.na[i] = clamp_pos(a[i]);
      p.nb[i] = clamp_pos(b[i]);
    end
    return p;
  endfunction

  task automatic report(string fld, logic [63:0] exp_v, logic [63:0] act_v);
    if (fail_count < 10)
      $display("mismatch %s: expected %h actual %h", fld, exp_v, act_v);
    fail_count++;
  endtask

  assign pending_count = projection_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    logic signed [31:0] av[3], bv[3];
    projection_t x;
    if (rst_n) begin
      if (start && !busy) begin
        av = '{in_ax, in_ay, in_az};
        bv = '{in_bx, in_by_coord, in_bz};
        projection_q.push_back(project(av, bv, in_a_pinned, in_b_pinned, in_rest_len));
      end
      if (out_valid) begin
        if (projection_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected word from block");
          fail_count++;
        end else begin
          x = projection_q.pop_front();
          if (out_new_ax !== x.na[0]) report("new_ax", x.na[0], out_new_ax);
          if (out_new_ay !== x.na[1]) report("new_ay", x.na[1], out_new_ay);
          if (out_new_az !== x.na[2]) report("new_az", x.na[2], out_new_az);
          if (out_new_bx !== x.nb[0]) report("new_bx", x.nb[0], out_new_bx);
          if (out_new_by !== x.nb[1]) report("new_by", x.nb[1], out_new_by);
          if (out_new_bz !== x.nb[2]) report("new_bz", x.nb[2], out_new_bz);
          if (out_length_error !== x.err) report("length_error", x.err, out_length_error);
          if (out_degenerate !== x.degen) report("degenerate", x.degen, out_degenerate);
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: sim/tb_distance_constraint_relax.sv
// testbench top: drives constraint words into the block and gives the verdict
`timescale 1ns / 100ps
`default_nettype none
module tb_distance_constraint_relax;
  import dcr_pkg::*;

  logic clk, rst_n, start, busy;
  logic signed [31:0] in_ax, in_ay, in_az, in_bx, in_by_coord, in_bz;
  logic in_a_pinned, in_b_pinned;
  logic [REST_W-1:0] in_rest_len;
  logic out_valid, out_degenerate;
  logic signed [31:0] out_new_ax, out_new_ay, out_new_az, out_new_bx, out_new_by, out_new_bz;
  logic [ERR_W-1:0] out_length_error;
  int fail_count, pending_count;
  int cycle_count;
  int idle_pct;

  // drain wait used after the last expected result has been checked
  localparam int PIPE_DEPTH = 107;
  localparam int CYCLE_LIMIT = 200000;

  distance_constraint_relax u_top (.*);
  dcr_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // watchdog on cycle count
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL distance_constraint_relax");
      $finish;
    end
  end

  // random coordinate, biased toward extremes and small values
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  // put one word on the input ports and hold it until accepted
  task automatic send_word(logic [31:0] a0, a1, a2, b0, b1, b2,
                           logic pa, pb, logic [30:0] rest);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_ax <= a0; in_ay <= a1; in_az <= a2;
    in_bx <= b0; in_by_coord <= b1; in_bz <= b2;
    in_a_pinned <= pa; in_b_pinned <= pb; in_rest_len <= rest;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [31:0] a0, a1, a2;
    a0 = pick_coord(); a1 = pick_coord(); a2 = pick_coord();
    // some near-coincident pairs, with a short rest length three times in four
    if ($urandom_range(0, 3) == 0)
      send_word(a0, a1, a2, a0 + $urandom_range(0, 20) - 10, a1 + $urandom_range(0, 20) - 10,
                a2 + $urandom_range(0, 20) - 10, 1'($urandom), 1'($urandom),
                $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 40)));
    else
      send_word(a0, a1, a2, pick_coord(), pick_coord(), pick_coord(),
                1'($urandom), 1'($urandom), 31'($urandom));
  endtask

  initial begin
    start = 0; rst_n = 0;
    in_ax = 0; in_ay = 0; in_az = 0; in_bx = 0; in_by_coord = 0; in_bz = 0;
    in_a_pinned = 0; in_b_pinned = 0; in_rest_len = 0;
    idle_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: every pin combination, coincident points, extremes, saturation
    for (int p = 0; p < 4; p++) begin
      send_word(32'h00030000, 0, 0, 0, 0, 0, p[0], p[1], 31'h00010000);
      send_word(32'h12345678, 32'h12345678, 32'h12345678, 32'h12345678, 32'h12345678,
                32'h12345678, p[0], p[1], 31'h7fffffff);
      send_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                32'h80000000, p[0], p[1], 31'd0);
      send_word(32'h7ffffff0, 0, 0, 32'h7fffffe0, 0, 0, p[0], p[1], 31'h7fffffff);
    end
    send_word(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 0,
              1'b0, 1'b0, 31'h7fffffff);
    send_word(0, 0, 0, 0, 0, 0, 1'b1, 1'b1, 31'd0);
    send_word(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 1'b0, 1'b0, 31'h55555555);
    send_word(32'h00000001, 0, 0, 0, 0, 0, 1'b0, 1'b0, 31'h2aaaaaaa);

    // random phases: sender idles sometimes, then more often, then never
    idle_pct = 37;
    repeat (270) send_random();
    idle_pct = 69;
    repeat (270) send_random();
    idle_pct = 0;
    repeat (270) send_random();
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
    if (fail_count == 0)
      $display("PASS distance_constraint_relax");
    else
      $display("FAIL distance_constraint_relax");
    $finish;
  end
endmodule
`default_nettype wire
